// ===== rtl/core/twn_pkg.sv =====
package twn_pkg;

    localparam int RUN_COUNT_BITS_DEF = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_LF  = 8'h0A;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    // what the back end must emit for one queued request
    typedef struct packed {
        logic       emit_nl;
        logic       emit_sp;
        logic       fin_one;
        logic       is_end;
        logic       sat;
        logic [7:0] fin_byte;
    } twn_flags_t;

    localparam int FLAGS_BITS = $bits(twn_flags_t);

    typedef enum logic [2:0] {
        STEP_NL  = 3'b001,
        STEP_SP  = 3'b010,
        STEP_FIN = 3'b100
    } twn_step_t;

endpackage

// ===== rtl/core/twn_front.sv =====
module twn_front #(
    parameter int RUN_COUNT_BITS = twn_pkg::RUN_COUNT_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_op,
    input  logic [7:0]                in_byte,
    input  logic                      q_full,
    output logic                      in_ready,
    output logic                      push,
    output logic [RUN_COUNT_BITS-1:0] push_nl,
    output logic [RUN_COUNT_BITS-1:0] push_sp,
    output twn_pkg::twn_flags_t       push_flags
);

    localparam logic [RUN_COUNT_BITS-1:0] RUN_MAX = '1;

    logic [RUN_COUNT_BITS-1:0] sp_reg, sp_next;
    logic [RUN_COUNT_BITS-1:0] nl_reg, nl_next;
    logic                      seen_reg, seen_next;
    logic                      sat_reg, sat_next;
    logic                      accept;
    logic                      is_content;
    logic                      is_space;

    assign in_ready   = !q_full;
    assign accept     = in_valid && in_ready;
    assign is_space   = (in_byte == twn_pkg::CH_TAB) || (in_byte == twn_pkg::CH_SP);
    assign is_content = !is_space && (in_byte != twn_pkg::CH_CR)
                        && (in_byte != twn_pkg::CH_LF);

    assign push    = accept && ((in_op == twn_pkg::OP_END) || is_content);
    assign push_nl = nl_reg;
    assign push_sp = sp_reg;

    always_comb
    begin
        push_flags.sat = sat_reg;
        if (in_op == twn_pkg::OP_END)
        begin
            push_flags.emit_nl  = (sp_reg != '0) && (nl_reg != '0);
            push_flags.emit_sp  = (sp_reg != '0);
            push_flags.fin_one  = (sp_reg != '0) || seen_reg;
            push_flags.fin_byte = push_flags.fin_one ? twn_pkg::CH_LF : 8'h00;
            push_flags.is_end   = 1'b1;
        end
        else
        begin
            push_flags.emit_nl  = (nl_reg != '0);
            push_flags.emit_sp  = (sp_reg != '0);
            push_flags.fin_one  = 1'b1;
            push_flags.fin_byte = in_byte;
            push_flags.is_end   = 1'b0;
        end
    end

    always_comb
    begin
        sp_next   = sp_reg;
        nl_next   = nl_reg;
        seen_next = seen_reg;
        sat_next  = sat_reg;
        if (accept)
        begin
            if (in_op == twn_pkg::OP_END)
            begin
                sp_next   = '0;
                nl_next   = '0;
                seen_next = 1'b0;
                sat_next  = 1'b0;
            end
            else if (is_space)
            begin
                if (sp_reg == RUN_MAX)
                    sat_next = 1'b1;
                else
                    sp_next = sp_reg + 1'b1;
            end
            else if (in_byte == twn_pkg::CH_LF)
            begin
                sp_next = '0;
                if (nl_reg == RUN_MAX)
                    sat_next = 1'b1;
                else
                    nl_next = nl_reg + 1'b1;
            end
            else if (is_content)
            begin
                sp_next   = '0;
                nl_next   = '0;
                seen_next = 1'b1;
                sat_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg   <= '0;
            nl_reg   <= '0;
            seen_reg <= 1'b0;
            sat_reg  <= 1'b0;
        end
        else
        begin
            sp_reg   <= sp_next;
            nl_reg   <= nl_next;
            seen_reg <= seen_next;
            sat_reg  <= sat_next;
        end
    end

endmodule

// ===== rtl/core/twn_queue.sv =====
module twn_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = twn_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output logic [WIDTH-1:0] head
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [CNT_BITS-1:0] DEPTH_C = CNT_BITS'(DEPTH);
    localparam logic [PTR_BITS-1:0] LAST_C  = PTR_BITS'(DEPTH - 1);

    logic [WIDTH-1:0]    store_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_reg, rd_reg;
    logic [CNT_BITS-1:0] cnt_reg;

    assign full      = (cnt_reg == DEPTH_C);
    assign not_empty = (cnt_reg != '0);
    assign head      = store_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == LAST_C) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == LAST_C) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ===== rtl/core/twn_back.sv =====
module twn_back #(
    parameter int RUN_COUNT_BITS = twn_pkg::RUN_COUNT_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  logic [RUN_COUNT_BITS-1:0] head_nl,
    input  logic [RUN_COUNT_BITS-1:0] head_sp,
    input  twn_pkg::twn_flags_t       head_flags,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [7:0]                out_byte,
    output logic [15:0]               out_repeat,
    output logic                      out_last,
    output logic                      out_end,
    output logic                      out_ovf
);

    twn_pkg::twn_step_t step_reg, step_next, sel;
    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic [15:0] repeat_reg;
    logic        last_reg, end_reg, ovf_reg;
    logic        load;
    logic [31:0] cnt_wide;
    logic [7:0]  sel_byte;

    assign load = q_valid && (!valid_reg || out_ready);
    assign pop  = load && (sel == twn_pkg::STEP_FIN);

    // first step still owed, starting at the stored position
    always_comb
    begin
        case (step_reg)
            twn_pkg::STEP_NL:
                sel = head_flags.emit_nl ? twn_pkg::STEP_NL :
                      head_flags.emit_sp ? twn_pkg::STEP_SP : twn_pkg::STEP_FIN;
            twn_pkg::STEP_SP:
                sel = head_flags.emit_sp ? twn_pkg::STEP_SP : twn_pkg::STEP_FIN;
            default:
                sel = twn_pkg::STEP_FIN;
        endcase
    end

    always_comb
    begin
        case (sel)
            twn_pkg::STEP_NL:
            begin
                cnt_wide  = 32'(head_nl);
                sel_byte  = twn_pkg::CH_LF;
                step_next = twn_pkg::STEP_SP;
            end
            twn_pkg::STEP_SP:
            begin
                cnt_wide  = 32'(head_sp);
                sel_byte  = twn_pkg::CH_SP;
                step_next = twn_pkg::STEP_FIN;
            end
            default:
            begin
                cnt_wide  = {31'd0, head_flags.fin_one};
                sel_byte  = head_flags.fin_byte;
                step_next = twn_pkg::STEP_NL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= twn_pkg::STEP_NL;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                step_reg  <= step_next;
            end
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= sel_byte;
            repeat_reg <= cnt_wide[15:0];
            last_reg   <= (sel == twn_pkg::STEP_FIN);
            end_reg    <= head_flags.is_end;
            ovf_reg    <= head_flags.sat;
        end
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign out_repeat = repeat_reg;
    assign out_last   = last_reg;
    assign out_end    = end_reg;
    assign out_ovf    = ovf_reg;

endmodule

// ===== rtl/core/text_whitespace_normalizer_unit.sv =====
// path: an accepted request is written into the request queue, and the back end then
//   loads it into the output register that drives its first result
// throughput: one request per cycle while the request queue is not full; a request
//   emits k results (k is 1 to 3) through the output stage; the queue absorbs bursts
// reset: rst_n asynchronous active low, clears run counters, flags, queue
//   pointers and output valid; no clearing pass
module text_whitespace_normalizer_unit #(
    parameter int RUN_COUNT_BITS = twn_pkg::RUN_COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] repeat_res
    output logic        m_tlast,   // run_last
    output logic [1:0]  m_tuser    // [0] stream_end, [1] overflow
);

    localparam int ENTRY_BITS = 2 * RUN_COUNT_BITS + twn_pkg::FLAGS_BITS;

    // front end to queue
    logic                      push;
    logic [RUN_COUNT_BITS-1:0] push_nl, push_sp;
    twn_pkg::twn_flags_t       push_flags;
    logic                      q_full;

    // queue to back end
    logic                      q_valid;
    logic                      pop;
    logic [ENTRY_BITS-1:0]     head;
    logic [RUN_COUNT_BITS-1:0] head_nl, head_sp;
    twn_pkg::twn_flags_t       head_flags;

    logic [7:0]                out_byte;
    logic [15:0]               out_repeat;
    logic                      out_end, out_ovf;

    // front end: classifies bytes, keeps the pending space and newline runs,
    // and queues a request for every content byte or end of stream
    twn_front #(
        .RUN_COUNT_BITS(RUN_COUNT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_op      (s_tuser),
        .in_byte    (s_tdata),
        .q_full     (q_full),
        .in_ready   (s_tready),
        .push       (push),
        .push_nl    (push_nl),
        .push_sp    (push_sp),
        .push_flags (push_flags)
    );

    // short request queue so either side can stall on its own
    twn_queue #(
        .WIDTH(ENTRY_BITS),
        .DEPTH(twn_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_nl, push_sp, push_flags}),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (head)
    );

    assign {head_nl, head_sp, head_flags} = head;

    // back end: expands each request into newline run, space run, final byte
    twn_back #(
        .RUN_COUNT_BITS(RUN_COUNT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .head_nl    (head_nl),
        .head_sp    (head_sp),
        .head_flags (head_flags),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (out_byte),
        .out_repeat (out_repeat),
        .out_last   (m_tlast),
        .out_end    (out_end),
        .out_ovf    (out_ovf)
    );

    assign m_tdata = {out_repeat, out_byte};
    assign m_tuser = {out_ovf, out_end};

endmodule

// ===== test/tb.sv =====
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD = 120;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_REQUESTS = 456;
    localparam int SAT_REPS = 65536;

    // one emitted run as it leaves the block
    typedef struct packed {
        logic [7:0]  ch;
        logic [15:0] count;
        logic        last;
        logic        fin;
        logic        ovf;
    } run_t;

    // one row of the directed table; typed_n > 0 means the runs are typed in
    typedef struct {
        logic       op;
        logic [7:0] ch;
        int         reps;
        int         typed_n;
        run_t       t0;
        run_t       t1;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;            // [7:0] in_byte
    logic        s_tuser = twn_pkg::OP_DATA; // [0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;                    // [7:0] out_byte, [23:8] repeat_res
    logic        m_tlast;
    logic [1:0]  m_tuser;                    // [0] stream_end, [1] overflow

    // predictor state, mirrors the block's pending runs
    logic [twn_pkg::RUN_COUNT_BITS_DEF-1:0] space_run;
    logic [twn_pkg::RUN_COUNT_BITS_DEF-1:0] newline_run;
    bit   text_seen;
    bit   run_saturated;

    run_t expected_runs[$];
    run_t typed_runs[$];
    row_t directed_rows[$];

    bit quiet;          // no random idling on either side while set
    bit hold_request;   // asks the result sink for one long hold-off
    int errors;
    int cycles;
    int requests_sent;
    int runs_checked;
    int streams_closed;

    text_whitespace_normalizer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    // hard stop, far beyond the slowest correct run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d runs outstanding", cycles,
                     expected_runs.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic run_t mk_run(logic [7:0] ch, logic [15:0] count, logic last,
                                    logic fin, logic ovf);
        run_t r;
        r.ch = ch;
        r.count = count;
        r.last = last;
        r.fin = fin;
        r.ovf = ovf;
        return r;
    endfunction

    // saturating increment of a pending run, flags the saturation
    function automatic logic [twn_pkg::RUN_COUNT_BITS_DEF-1:0] bump_run(
        logic [twn_pkg::RUN_COUNT_BITS_DEF-1:0] c);
        if (&c)
        begin
            run_saturated = 1'b1;
            return c;
        end
        return c + 1'b1;
    endfunction

    // mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // works out the runs one request emits and updates the pending state
    task automatic predict_runs(input logic op, input logic [7:0] ch, input bit keep);
        run_t r[$];
        if (op == twn_pkg::OP_END)
        begin
            if (space_run != 0)
            begin
                if (newline_run != 0)
                    r.push_back(mk_run(twn_pkg::CH_LF, newline_run, 1'b0, 1'b1,
                                       run_saturated));
                r.push_back(mk_run(twn_pkg::CH_SP, space_run, 1'b0, 1'b1, run_saturated));
                r.push_back(mk_run(twn_pkg::CH_LF, 16'd1, 1'b0, 1'b1, run_saturated));
            end
            else if (text_seen)
                r.push_back(mk_run(twn_pkg::CH_LF, 16'd1, 1'b0, 1'b1, run_saturated));
            else
                r.push_back(mk_run(8'h00, 16'd0, 1'b0, 1'b1, run_saturated));
            space_run = '0;
            newline_run = '0;
            text_seen = 1'b0;
            streams_closed++;
        end
        else if (ch == twn_pkg::CH_CR)
        begin
            // carriage returns vanish
        end
        else if (ch == twn_pkg::CH_TAB || ch == twn_pkg::CH_SP)
            space_run = bump_run(space_run);
        else if (ch == twn_pkg::CH_LF)
        begin
            // a newline kills any spaces before it
            space_run = '0;
            newline_run = bump_run(newline_run);
        end
        else
        begin
            if (newline_run != 0)
                r.push_back(mk_run(twn_pkg::CH_LF, newline_run, 1'b0, 1'b0, run_saturated));
            if (space_run != 0)
                r.push_back(mk_run(twn_pkg::CH_SP, space_run, 1'b0, 1'b0, run_saturated));
            r.push_back(mk_run(ch, 16'd1, 1'b0, 1'b0, run_saturated));
            space_run = '0;
            newline_run = '0;
            text_seen = 1'b1;
        end
        if (r.size() > 0)
        begin
            r[r.size() - 1].last = 1'b1;
            run_saturated = 1'b0;
        end
        if (keep)
            foreach (r[i])
                expected_runs.push_back(r[i]);
    endtask

    // offers one request, waits for the handshake, then idles for a random gap
    task automatic offer(input logic op, input logic [7:0] ch, input bit keep);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= ch;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        predict_runs(op, ch, keep);
        if (!keep)
        begin
            foreach (typed_runs[i])
                expected_runs.push_back(typed_runs[i]);
            typed_runs.delete();
        end
        requests_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic add_row(input logic op, input logic [7:0] ch, input int reps = 1,
                           input int typed_n = 0, input run_t t0 = '0,
                           input run_t t1 = '0);
        row_t row;
        row.op = op;
        row.ch = ch;
        row.reps = reps;
        row.typed_n = typed_n;
        row.t0 = t0;
        row.t1 = t1;
        directed_rows.push_back(row);
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        errors++;
        $display("mismatch on %s at cycle %0d: got %0h, want %0h", field, cycles, got,
                 want);
    endtask

    // random text: mostly words, blanks and line breaks, now and then an end of stream
    task automatic random_request(output logic op, output logic [7:0] ch);
        int r;
        r = $urandom_range(0, 99);
        op = twn_pkg::OP_DATA;
        if (r < 45)
            ch = 8'($urandom_range(8'h21, 8'h7E));
        else if (r < 60)
            ch = twn_pkg::CH_SP;
        else if (r < 66)
            ch = twn_pkg::CH_TAB;
        else if (r < 76)
            ch = twn_pkg::CH_LF;
        else if (r < 80)
            ch = twn_pkg::CH_CR;
        else if (r < 96)
            ch = 8'($urandom_range(0, 255));
        else
        begin
            op = twn_pkg::OP_END;
            ch = 8'($urandom_range(0, 255));
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // compares every accepted run with the oldest expectation, field by field
    initial
    begin : result_check
        run_t got;
        run_t want;
        forever
        begin
            @(posedge clk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
            begin
                got = mk_run(m_tdata[7:0], m_tdata[23:8], m_tlast, m_tuser[0], m_tuser[1]);
                if (expected_runs.size() == 0)
                    report_mismatch("unexpected run", int'(got.ch), 0);
                else
                begin
                    want = expected_runs.pop_front();
                    runs_checked++;
                    if (got.ch !== want.ch)
                        report_mismatch("out_byte", int'(got.ch), int'(want.ch));
                    if (got.count !== want.count)
                        report_mismatch("repeat_res", int'(got.count), int'(want.count));
                    if (got.last !== want.last)
                        report_mismatch("run_last", int'(got.last), int'(want.last));
                    if (got.fin !== want.fin)
                        report_mismatch("stream_end", int'(got.fin), int'(want.fin));
                    if (got.ovf !== want.ovf)
                        report_mismatch("overflow", int'(got.ovf), int'(want.ovf));
                end
            end
        end
    end

    initial
    begin : stimulus
        logic       op;
        logic [7:0] ch;
        space_run = '0;
        newline_run = '0;
        text_seen = 1'b0;
        run_saturated = 1'b0;

        // empty stream straight after reset, then plain content at the extremes
        add_row(twn_pkg::OP_END, 8'h00, 1, 1, mk_run(8'h00, 16'd0, 1'b1, 1'b1, 1'b0));
        add_row(twn_pkg::OP_DATA, 8'h41, 1, 1, mk_run(8'h41, 16'd1, 1'b1, 1'b0, 1'b0));
        add_row(twn_pkg::OP_DATA, 8'hFF, 1, 1, mk_run(8'hFF, 16'd1, 1'b1, 1'b0, 1'b0));
        add_row(twn_pkg::OP_DATA, 8'h00);
        // blanks and tabs merge, carriage return dropped, then content flushes
        add_row(twn_pkg::OP_DATA, twn_pkg::CH_SP, 3);
        add_row(twn_pkg::OP_DATA, twn_pkg::CH_TAB);
        add_row(twn_pkg::OP_DATA, twn_pkg::CH_CR);
        add_row(twn_pkg::OP_DATA, 8'h62);
        // spaces before a line break are dropped
        add_row(twn_pkg::OP_DATA, twn_pkg::CH_SP, 2);
        add_row(twn_pkg::OP_DATA, twn_pkg::CH_LF, 2);
        add_row(twn_pkg::OP_DATA, twn_pkg::CH_TAB);
        add_row(twn_pkg::OP_DATA, 8'h80);
        // trailing spaces at end of stream, in_byte ignored
        add_row(twn_pkg::OP_DATA, twn_pkg::CH_SP, 2);
        add_row(twn_pkg::OP_END, 8'hFF);
        // spaces with no content: newline run, space run, one newline
        add_row(twn_pkg::OP_DATA, twn_pkg::CH_LF);
        add_row(twn_pkg::OP_DATA, twn_pkg::CH_SP);
        add_row(twn_pkg::OP_END, 8'h5A);
        // only line breaks: still an empty stream
        add_row(twn_pkg::OP_DATA, twn_pkg::CH_CR);
        add_row(twn_pkg::OP_DATA, twn_pkg::CH_LF, 3);
        add_row(twn_pkg::OP_END, 8'h00, 1, 1, mk_run(8'h00, 16'd0, 1'b1, 1'b1, 1'b0));
        // trailing newlines collapse to one
        add_row(twn_pkg::OP_DATA, 8'h7A);
        add_row(twn_pkg::OP_DATA, twn_pkg::CH_LF, 2);
        add_row(twn_pkg::OP_END, 8'h00);
        // space run saturates
        add_row(twn_pkg::OP_DATA, twn_pkg::CH_SP, SAT_REPS);
        add_row(twn_pkg::OP_END, 8'h00, 1, 2,
                mk_run(twn_pkg::CH_SP, 16'hFFFF, 1'b0, 1'b1, 1'b1),
                mk_run(twn_pkg::CH_LF, 16'd1, 1'b1, 1'b1, 1'b1));
        // newline run saturates, flag clears after the next emission
        add_row(twn_pkg::OP_DATA, twn_pkg::CH_LF, SAT_REPS);
        add_row(twn_pkg::OP_DATA, 8'h78, 1, 2,
                mk_run(twn_pkg::CH_LF, 16'hFFFF, 1'b0, 1'b0, 1'b1),
                mk_run(8'h78, 16'd1, 1'b1, 1'b0, 1'b1));
        add_row(twn_pkg::OP_DATA, 8'h79);
        add_row(twn_pkg::OP_END, 8'h00);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            // no idling through the long saturating runs, keeps the run short
            quiet = directed_rows[i].reps > 1000;
            for (int k = 0; k < directed_rows[i].reps; k++)
            begin
                if (directed_rows[i].typed_n > 0 && k == directed_rows[i].reps - 1)
                begin
                    typed_runs.push_back(directed_rows[i].t0);
                    if (directed_rows[i].typed_n > 1)
                        typed_runs.push_back(directed_rows[i].t1);
                    offer(directed_rows[i].op, directed_rows[i].ch, 1'b0);
                end
                else
                    offer(directed_rows[i].op, directed_rows[i].ch, 1'b1);
            end
        end
        quiet = 1'b0;

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            // sink holds off while requests keep coming, so the queue backs up
            if (n == 40)
            begin
                hold_request = 1'b1;
                quiet = 1'b1;
            end
            if (n == 70)
                quiet = 1'b0;
            // a stretch with no idling at all
            if (n == 120)
                quiet = 1'b1;
            if (n == 180)
                quiet = 1'b0;
            // sender pauses until everything owed has come out
            if (n == 300)
            begin
                s_tvalid <= 1'b0;
                while (expected_runs.size() != 0)
                    @(posedge clk);
            end
            random_request(op, ch);
            offer(op, ch, 1'b1);
        end
        s_tvalid <= 1'b0;

        while (expected_runs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d requests, %0d runs checked, %0d streams closed", requests_sent,
                 runs_checked, streams_closed);
        $display("covered blank, tab, cr and lf handling, empty streams and saturation");
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/twn_pkg.sv
rtl/core/twn_front.sv
rtl/core/twn_queue.sv
rtl/core/twn_back.sv
rtl/core/text_whitespace_normalizer_unit.sv
test/tb.sv
